// ----- rtl/core/aef_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the axis event filter.
// No dependencies; every other file of the block imports this package.
package aef_pkg;

	localparam int DATA_W = 32;
	localparam int FUZZ_W = 31;
	localparam int VERDICT_W = 2;
	localparam int INDEX_W = 3;

	// Saturation bounds for relative accumulation; VALUE_BITS ranges over 8..32
	localparam int VALUE_BITS = 32;
	localparam longint VAL_MAX_L = (longint'(1) << (VALUE_BITS - 1)) - 1;
	localparam longint VAL_MIN_L = -VAL_MAX_L - 1;
	localparam logic signed [DATA_W:0] SUM_MAX = (DATA_W + 1)'(VAL_MAX_L);
	localparam logic signed [DATA_W:0] SUM_MIN = (DATA_W + 1)'(VAL_MIN_L);

	typedef logic signed [DATA_W-1:0] value_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_DISCARD = 2'd0,
		VERDICT_NEUTRAL = 2'd1,
		VERDICT_EMIT    = 2'd2
	} verdict_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_RANGE_MIN    = 3'd0,
		REG_RANGE_MAX    = 3'd1,
		REG_FUZZ_BAND    = 3'd2,
		REG_FLAT_ZONE    = 3'd3,
		REG_DIRECT_MODE  = 3'd4,
		REG_REAL_FUZZ    = 3'd5,
		REG_FRAMED       = 3'd6,
		REG_AXIS_ENABLED = 3'd7
	} reg_index_t;

endpackage

// ----- rtl/core/aef_in_if.sv -----
`timescale 1ns / 1ps
// Input event channel of the axis event filter: valid/ready plus event payload.
// Depends on aef_pkg.
interface aef_in_if;
	import aef_pkg::*;

	logic   valid;
	logic   ready;
	logic   axis_known;
	value_t sample_value;

	modport source (output valid, output axis_known, output sample_value, input ready);
	modport sink (input valid, input axis_known, input sample_value, output ready);
endinterface

// ----- rtl/core/aef_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the axis event filter: valid/ready plus verdict and value.
// Depends on aef_pkg.
interface aef_out_if;
	import aef_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	value_t               result_value;

	modport source (output valid, output verdict, output result_value, input ready);
	modport sink (input valid, input verdict, input result_value, output ready);
endinterface

// ----- rtl/core/axis_event_filter.sv -----
`timescale 1ns / 1ps
// Axis event filter top level: input register, filter logic, result register.
// Depends on aef_pkg, aef_in_if and aef_out_if.

// Each event transfer on "sample" produces exactly one result transfer on
// "result", in order. The block takes one event per cycle when the result
// side keeps up: an event is captured in an input register, filtered by one
// pass of compare, clamp and add logic against the stored last value, and
// moves on into the result register once that register is empty or being
// taken. The stored last value updates as the event moves into the result
// register, so the next event sees it at once. When the result register is
// full and not taken, the input register holds and "sample.ready" drops only
// once both stages are occupied. Registers are written through
// wr_en/wr_index/wr_data and must only change while no event is in flight.
module axis_event_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [aef_pkg::INDEX_W-1:0] wr_index,
	input  logic [aef_pkg::DATA_W-1:0]  wr_data,
	aef_in_if.sink                 sample,
	aef_out_if.source              result
);
	import aef_pkg::*;

	// Configuration registers
	value_t            range_min_q;
	value_t            range_max_q;
	logic [FUZZ_W-1:0] fuzz_band_q;
	logic [FUZZ_W-1:0] flat_zone_q;
	logic              direct_mode_q;
	logic              real_fuzz_q;
	logic              framed_q;
	logic              axis_enabled_q;

	// Filter state
	value_t last_value_q;

	// Input stage
	logic   valid_s1;
	logic   known_s1;
	value_t sample_s1;

	// Result stage
	logic     out_valid_q;
	verdict_t verdict_q;
	value_t   value_q;

	logic advance;

	// Combinational filter outputs
	verdict_t              verdict_d;
	value_t                value_d;
	value_t                last_d;
	logic signed [DATA_W:0] diff;
	logic [DATA_W:0]       mag_diff;
	logic [DATA_W:0]       mag_sample;
	logic                  fuzz_hit;
	value_t                direct_v;
	logic signed [DATA_W:0] sum_raw;
	value_t                sum_sat;
	value_t                framed_v;
	logic                  out_of_range;

	// Move the held event into the result register when that register frees up
	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	assign result.valid = out_valid_q;
	assign result.verdict = verdict_q;
	assign result.result_value = value_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= value_t'({1'b1, {(DATA_W-1){1'b0}}});
			range_max_q <= value_t'({1'b0, {(DATA_W-1){1'b1}}});
			fuzz_band_q <= '0;
			flat_zone_q <= '0;
			direct_mode_q <= 1'b0;
			real_fuzz_q <= 1'b0;
			framed_q <= 1'b0;
			axis_enabled_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_RANGE_MIN:    range_min_q <= value_t'(wr_data);
				REG_RANGE_MAX:    range_max_q <= value_t'(wr_data);
				REG_FUZZ_BAND:    fuzz_band_q <= wr_data[FUZZ_W-1:0];
				REG_FLAT_ZONE:    flat_zone_q <= wr_data[FUZZ_W-1:0];
				REG_DIRECT_MODE:  direct_mode_q <= wr_data[0];
				REG_REAL_FUZZ:    real_fuzz_q <= wr_data[0];
				REG_FRAMED:       framed_q <= wr_data[0];
				REG_AXIS_ENABLED: axis_enabled_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Filter datapath. Differences and magnitudes are one bit wider than the
	// data so the most negative sample keeps its true magnitude of 2^31.
	always_comb begin
		diff = {sample_s1[DATA_W-1], sample_s1} - {last_value_q[DATA_W-1], last_value_q};
		mag_diff = diff[DATA_W] ? unsigned'(-diff) : unsigned'(diff);
		mag_sample = sample_s1[DATA_W-1] ? unsigned'(-{1'b1, sample_s1})
		                                 : unsigned'({1'b0, sample_s1});
		fuzz_hit = mag_diff <= {2'b00, fuzz_band_q};

		// Direct mode: clamp first (min wins over max), then flat zone
		if (sample_s1 < range_min_q) begin
			direct_v = range_min_q;
		end else if (sample_s1 > range_max_q) begin
			direct_v = range_max_q;
		end else if (mag_sample <= {2'b00, flat_zone_q}) begin
			direct_v = '0;
		end else begin
			direct_v = sample_s1;
		end

		// Relative mode: saturating accumulate
		sum_raw = {last_value_q[DATA_W-1], last_value_q} + {sample_s1[DATA_W-1], sample_s1};
		if (sum_raw < SUM_MIN) begin
			sum_sat = SUM_MIN[DATA_W-1:0];
		end else if (sum_raw > SUM_MAX) begin
			sum_sat = SUM_MAX[DATA_W-1:0];
		end else begin
			sum_sat = sum_raw[DATA_W-1:0];
		end

		if (sum_sat < range_min_q) begin
			framed_v = range_min_q;
		end else if (sum_sat > range_max_q) begin
			framed_v = range_max_q;
		end else begin
			framed_v = sum_sat;
		end
		out_of_range = (sum_sat < range_min_q) || (sum_sat > range_max_q);

		verdict_d = VERDICT_NEUTRAL;
		value_d = sample_s1;
		last_d = last_value_q;

		if (!known_s1 || !axis_enabled_q) begin
			// Pass through untouched
			verdict_d = VERDICT_NEUTRAL;
		end else if (direct_mode_q) begin
			if (fuzz_hit) begin
				verdict_d = VERDICT_DISCARD;
				if (real_fuzz_q) begin
					last_d = sample_s1;
				end
			end else begin
				value_d = direct_v;
				if (direct_v == last_value_q) begin
					verdict_d = VERDICT_DISCARD;
				end else begin
					last_d = direct_v;
					verdict_d = VERDICT_EMIT;
				end
			end
		end else begin
			value_d = framed_q ? framed_v : sum_sat;
			if (value_d == last_value_q) begin
				verdict_d = VERDICT_NEUTRAL;
			end else begin
				last_d = value_d;
				// Unframed sums outside the range are stored but not emitted
				verdict_d = (!framed_q && out_of_range) ? VERDICT_NEUTRAL : VERDICT_EMIT;
			end
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// Input stage payload: load on every transfer
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			known_s1 <= sample.axis_known;
			sample_s1 <= sample.sample_value;
		end
	end

	// Result stage control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_value_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				last_value_q <= last_d;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict_d;
			value_q <= value_d;
		end
	end

endmodule
